// ===== hdl/gvssl_pkg.sv =====
// Shared types, sizes and codes of the grouped volume-sorted start/run lists.
package gvssl_pkg;

  // Table and pool sizes
  localparam int GROUP_SLOTS  = 64;
  localparam int POOL_ENTRIES = 64;
  localparam int MAX_RESULTS  = 64;

  localparam int GIDX_W = $clog2(GROUP_SLOTS);
  localparam int GCNT_W = $clog2(GROUP_SLOTS + 1);
  localparam int IDX_W  = $clog2(POOL_ENTRIES);
  localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);
  localparam int TOT_W  = $clog2(POOL_ENTRIES + 1);
  localparam int STEP_MAX = (POOL_ENTRIES > MAX_RESULTS) ? POOL_ENTRIES : MAX_RESULTS;
  localparam int STEP_W = $clog2(STEP_MAX + 1);

  localparam logic [PTR_W-1:0] NO_ENTRY = PTR_W'(POOL_ENTRIES);

  // Operation codes
  localparam logic [1:0] OP_CLEAR     = 2'd0;
  localparam logic [1:0] OP_ADD_RUN   = 2'd1;
  localparam logic [1:0] OP_ADD_START = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_POOL_FULL  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  // Group table row
  typedef struct packed {
    logic [31:0]      key;
    logic [PTR_W-1:0] shead;
    logic [PTR_W-1:0] rhead;
    logic [TOT_W-1:0] total;
  } grow_t;

  typedef struct packed {
    logic [15:0] emitter;
    logic [15:0] volume;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [13:0] pitch;
  } start_pay_t;

  typedef struct packed {
    logic [15:0] emitter;
    logic [15:0] volume;
  } run_pay_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;
    logic       clear;
    logic       g_rd;
    logic       g_next;
    logic       g_latch;
    logic       g_new;
    logic       walk_init;
    logic       walk_rd;
    logic       walk_adv;
    logic       ins_node;
    logic       ins_link;
    logic       set_status;
    logic [1:0] status;
    logic       use_total;
    logic       push_res;
    logic       push_entry;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       groups_empty;
    logic       groups_full;
    logic       key_hit;
    logic       g_at_end;
    logic       pool_full;
    logic       cur_end;
    logic       brk;
    logic       rd_last;
    logic       out_free;
  } stat_t;

  // Clamp a running count to the 7-bit result field
  function automatic logic [6:0] sat_total(input logic [TOT_W-1:0] t);
    if (int'(t) > 127) return 7'd127;
    else return 7'(t);
  endfunction

endpackage

// ===== hdl/gvssl_ram.sv =====
// Generic single-port RAM with registered read.
module gvssl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/gvssl_dp.sv =====
// Datapath: item registers, group table, list pools, walk pointers, result register.
module gvssl_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gvssl_pkg::cmd_t     cmd,
  output gvssl_pkg::stat_t    st,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_group_id,
  input  logic [15:0]         in_emitter_handle,
  input  logic [15:0]         in_volume,
  input  logic signed [15:0]  in_pan_x,
  input  logic signed [15:0]  in_pan_y,
  input  logic signed [15:0]  in_pan_z,
  input  logic [13:0]         in_pitch_ratio,
  input  logic                in_list_select,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [15:0]         out_emitter,
  output logic [15:0]         out_volume,
  output logic signed [15:0]  out_pan_x,
  output logic signed [15:0]  out_pan_y,
  output logic signed [15:0]  out_pan_z,
  output logic [13:0]         out_pitch,
  output logic [6:0]          out_running_total,
  output logic                out_last
);

  // Latched item
  logic [1:0]  op_r;
  logic [31:0] key_r;
  logic [15:0] em_r, vol_r, px_r, py_r, pz_r;
  logic [13:0] pitch_r;
  logic        lsel_r;

  // Control and walk state
  logic [gvssl_pkg::GIDX_W-1:0] g_r;
  logic [gvssl_pkg::GCNT_W-1:0] groups_used_r;
  logic [gvssl_pkg::PTR_W-1:0]  start_used_r, run_used_r;
  logic [gvssl_pkg::PTR_W-1:0]  prev_r, cur_r;
  logic [gvssl_pkg::STEP_W-1:0] steps_r;
  gvssl_pkg::grow_t             row_r;
  logic [1:0]                   status_r;
  logic                         use_tot_r;

  // Result register
  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic [15:0] o_em_r, o_vol_r, o_px_r, o_py_r, o_pz_r;
  logic [13:0] o_pitch_r;
  logic [6:0]  o_tot_r;
  logic        o_last_r;

  // Memory ports
  gvssl_pkg::grow_t             grp_wd, grp_rd, new_row, row_upd;
  logic                         grp_we, grp_re;
  logic [gvssl_pkg::GIDX_W-1:0] grp_addr;
  logic [gvssl_pkg::PTR_W-1:0]  slink_rd, rlink_rd, link_rd, link_wd;
  logic                         slink_we, rlink_we, slink_re, rlink_re;
  logic [gvssl_pkg::IDX_W-1:0]  link_addr, pay_addr, n_idx;
  gvssl_pkg::start_pay_t        spay_rd, spay_wd;
  gvssl_pkg::run_pay_t          rpay_rd, rpay_wd;
  logic                         spay_we, rpay_we, spay_re, rpay_re;

  logic use_run, prev_none, out_free;

  assign use_run   = (op_r == gvssl_pkg::OP_ADD_RUN) ||
                     ((op_r == gvssl_pkg::OP_READ) && lsel_r);
  assign prev_none = (prev_r == gvssl_pkg::NO_ENTRY);
  assign out_free  = !out_valid_r || out_ready;
  assign n_idx     = use_run ? run_used_r[gvssl_pkg::IDX_W-1:0]
                             : start_used_r[gvssl_pkg::IDX_W-1:0];
  assign link_rd   = use_run ? rlink_rd : slink_rd;

  // Build fresh and updated group rows
  always_comb begin
    new_row       = '0;
    new_row.key   = key_r;
    new_row.shead = gvssl_pkg::NO_ENTRY;
    new_row.rhead = gvssl_pkg::NO_ENTRY;
    row_upd       = row_r;
    if (prev_none) begin
      if (use_run) row_upd.rhead = gvssl_pkg::PTR_W'(n_idx);
      else row_upd.shead = gvssl_pkg::PTR_W'(n_idx);
    end
    if (use_run) begin
      row_upd.total = row_r.total + gvssl_pkg::TOT_W'(1);
    end
  end

  // Steer memory ports
  always_comb begin
    grp_we   = cmd.g_new || cmd.ins_link;
    grp_re   = cmd.g_rd;
    grp_addr = cmd.g_new ? groups_used_r[gvssl_pkg::GIDX_W-1:0] : g_r;
    grp_wd   = cmd.g_new ? new_row : row_upd;

    if (cmd.ins_node) link_addr = n_idx;
    else if (cmd.ins_link) link_addr = prev_r[gvssl_pkg::IDX_W-1:0];
    else link_addr = cur_r[gvssl_pkg::IDX_W-1:0];
    link_wd  = cmd.ins_node ? cur_r : gvssl_pkg::PTR_W'(n_idx);
    slink_we = !use_run && (cmd.ins_node || (cmd.ins_link && !prev_none));
    rlink_we = use_run && (cmd.ins_node || (cmd.ins_link && !prev_none));
    slink_re = !use_run && cmd.walk_rd;
    rlink_re = use_run && cmd.walk_rd;

    pay_addr = cmd.ins_node ? n_idx : cur_r[gvssl_pkg::IDX_W-1:0];
    spay_we  = !use_run && cmd.ins_node;
    rpay_we  = use_run && cmd.ins_node;
    spay_re  = !use_run && cmd.walk_rd;
    rpay_re  = use_run && cmd.walk_rd;
    spay_wd  = '{emitter: em_r, volume: vol_r, px: px_r, py: py_r, pz: pz_r,
                 pitch: pitch_r};
    rpay_wd  = '{emitter: em_r, volume: vol_r};
  end

  gvssl_ram #(.WIDTH($bits(gvssl_pkg::grow_t)), .DEPTH(gvssl_pkg::GROUP_SLOTS)) u_grp (
    .clk(clk), .we(grp_we), .re(grp_re), .addr(grp_addr), .wdata(grp_wd), .rdata(grp_rd)
  );
  gvssl_ram #(.WIDTH(gvssl_pkg::PTR_W), .DEPTH(gvssl_pkg::POOL_ENTRIES)) u_slink (
    .clk(clk), .we(slink_we), .re(slink_re), .addr(link_addr), .wdata(link_wd),
    .rdata(slink_rd)
  );
  gvssl_ram #(.WIDTH(gvssl_pkg::PTR_W), .DEPTH(gvssl_pkg::POOL_ENTRIES)) u_rlink (
    .clk(clk), .we(rlink_we), .re(rlink_re), .addr(link_addr), .wdata(link_wd),
    .rdata(rlink_rd)
  );
  gvssl_ram #(.WIDTH($bits(gvssl_pkg::start_pay_t)), .DEPTH(gvssl_pkg::POOL_ENTRIES)) u_spay (
    .clk(clk), .we(spay_we), .re(spay_re), .addr(pay_addr), .wdata(spay_wd), .rdata(spay_rd)
  );
  gvssl_ram #(.WIDTH($bits(gvssl_pkg::run_pay_t)), .DEPTH(gvssl_pkg::POOL_ENTRIES)) u_rpay (
    .clk(clk), .we(rpay_we), .re(rpay_re), .addr(pay_addr), .wdata(rpay_wd), .rdata(rpay_rd)
  );

  // Status back to the controller
  always_comb begin
    st.op           = op_r;
    st.groups_empty = (groups_used_r == '0);
    st.groups_full  = (groups_used_r == gvssl_pkg::GCNT_W'(gvssl_pkg::GROUP_SLOTS));
    st.key_hit      = (grp_rd.key == key_r);
    st.g_at_end     = ((gvssl_pkg::GCNT_W'(g_r) + gvssl_pkg::GCNT_W'(1)) == groups_used_r);
    st.pool_full    = use_run ? (run_used_r == gvssl_pkg::NO_ENTRY)
                              : (start_used_r == gvssl_pkg::NO_ENTRY);
    st.cur_end      = (cur_r >= gvssl_pkg::NO_ENTRY) ||
                      (steps_r == gvssl_pkg::STEP_W'(gvssl_pkg::POOL_ENTRIES));
    st.brk          = use_run ? (rpay_rd.volume > vol_r) : (spay_rd.volume < vol_r);
    st.rd_last      = (link_rd >= gvssl_pkg::NO_ENTRY) ||
                      ((steps_r + gvssl_pkg::STEP_W'(1)) ==
                       gvssl_pkg::STEP_W'(gvssl_pkg::MAX_RESULTS));
    st.out_free     = out_free;
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r    <= in_op;
      key_r   <= in_group_id;
      em_r    <= in_emitter_handle;
      vol_r   <= in_volume;
      px_r    <= in_pan_x;
      py_r    <= in_pan_y;
      pz_r    <= in_pan_z;
      pitch_r <= in_pitch_ratio;
      lsel_r  <= in_list_select;
    end
  end

  // Advance search and walk registers
  always_ff @(posedge clk) begin
    if (cmd.take) g_r <= '0;
    else if (cmd.g_next) g_r <= g_r + gvssl_pkg::GIDX_W'(1);
    else if (cmd.g_new) g_r <= groups_used_r[gvssl_pkg::GIDX_W-1:0];

    if (cmd.g_latch) row_r <= grp_rd;
    else if (cmd.g_new) row_r <= new_row;
    else if (cmd.ins_link) row_r <= row_upd;

    if (cmd.walk_init) begin
      prev_r  <= gvssl_pkg::NO_ENTRY;
      cur_r   <= use_run ? row_r.rhead : row_r.shead;
      steps_r <= '0;
    end else if (cmd.walk_adv) begin
      prev_r  <= cur_r;
      cur_r   <= link_rd;
      steps_r <= steps_r + gvssl_pkg::STEP_W'(1);
    end

    if (cmd.set_status) begin
      status_r  <= cmd.status;
      use_tot_r <= cmd.use_total;
    end
  end

  // Fill counts
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      groups_used_r <= '0;
      start_used_r  <= '0;
      run_used_r    <= '0;
    end else begin
      if (cmd.g_new) groups_used_r <= groups_used_r + gvssl_pkg::GCNT_W'(1);
      if (cmd.ins_link && use_run) run_used_r <= run_used_r + gvssl_pkg::PTR_W'(1);
      if (cmd.ins_link && !use_run) start_used_r <= start_used_r + gvssl_pkg::PTR_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_res || cmd.push_entry) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_res) begin
      o_status_r <= status_r;
      o_em_r     <= '0;
      o_vol_r    <= '0;
      o_px_r     <= '0;
      o_py_r     <= '0;
      o_pz_r     <= '0;
      o_pitch_r  <= '0;
      o_tot_r    <= use_tot_r ? gvssl_pkg::sat_total(row_r.total) : 7'd0;
      o_last_r   <= 1'b1;
    end else if (cmd.push_entry) begin
      o_status_r <= gvssl_pkg::ST_OK;
      o_em_r     <= use_run ? rpay_rd.emitter : spay_rd.emitter;
      o_vol_r    <= use_run ? rpay_rd.volume : spay_rd.volume;
      o_px_r     <= use_run ? 16'd0 : spay_rd.px;
      o_py_r     <= use_run ? 16'd0 : spay_rd.py;
      o_pz_r     <= use_run ? 16'd0 : spay_rd.pz;
      o_pitch_r  <= use_run ? 14'd0 : spay_rd.pitch;
      o_tot_r    <= gvssl_pkg::sat_total(row_r.total);
      o_last_r   <= st.rd_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_emitter       = o_em_r;
  assign out_volume        = o_vol_r;
  assign out_pan_x         = o_px_r;
  assign out_pan_y         = o_py_r;
  assign out_pan_z         = o_pz_r;
  assign out_pitch         = o_pitch_r;
  assign out_running_total = o_tot_r;
  assign out_last          = o_last_r;

endmodule

// ===== hdl/gvssl_ctrl.sv =====
// Controller: sequences group search, list walks, inserts and result pushes.
module gvssl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gvssl_pkg::stat_t st,
  output gvssl_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_LOOK = 11'b00000000010,
    S_GCMP = 11'b00000000100,
    S_GOT  = 11'b00000001000,
    S_WRD  = 11'b00000010000,
    S_WCMP = 11'b00000100000,
    S_INS1 = 11'b00001000000,
    S_INS2 = 11'b00010000000,
    S_EMIT = 11'b00100000000,
    S_RRD  = 11'b01000000000,
    S_RCMP = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (st.op == gvssl_pkg::OP_CLEAR) begin
          cmd.clear      = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = gvssl_pkg::ST_OK;
          state_nxt      = S_EMIT;
        end else if (st.groups_empty) begin
          // no groups: treat as not found
          cmd.set_status = 1'b1;
          if (st.op == gvssl_pkg::OP_READ) begin
            cmd.status = gvssl_pkg::ST_NOT_FOUND;
            state_nxt  = S_EMIT;
          end else begin
            cmd.set_status = 1'b0;
            cmd.g_new      = 1'b1;
            state_nxt      = S_GOT;
          end
        end else begin
          cmd.g_rd  = 1'b1;
          state_nxt = S_GCMP;
        end
      end
      S_GCMP: begin
        if (st.key_hit) begin
          cmd.g_latch = 1'b1;
          state_nxt   = S_GOT;
        end else if (!st.g_at_end) begin
          cmd.g_next = 1'b1;
          state_nxt  = S_LOOK;
        end else if (st.op == gvssl_pkg::OP_READ) begin
          cmd.set_status = 1'b1;
          cmd.status     = gvssl_pkg::ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else if (st.groups_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = gvssl_pkg::ST_TABLE_FULL;
          state_nxt      = S_EMIT;
        end else begin
          cmd.g_new = 1'b1;
          state_nxt = S_GOT;
        end
      end
      S_GOT: begin
        if (st.op != gvssl_pkg::OP_READ && st.pool_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = gvssl_pkg::ST_POOL_FULL;
          cmd.use_total  = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = (st.op == gvssl_pkg::OP_READ) ? S_RRD : S_WRD;
        end
      end
      S_WRD: begin
        if (st.cur_end) begin
          state_nxt = S_INS1;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WCMP;
        end
      end
      S_WCMP: begin
        if (st.brk) begin
          state_nxt = S_INS1;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_WRD;
        end
      end
      S_INS1: begin
        cmd.ins_node = 1'b1;
        state_nxt    = S_INS2;
      end
      S_INS2: begin
        cmd.ins_link   = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = gvssl_pkg::ST_OK;
        cmd.use_total  = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.push_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RRD: begin
        if (st.cur_end) begin
          // empty list
          cmd.set_status = 1'b1;
          cmd.status     = gvssl_pkg::ST_OK;
          cmd.use_total  = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_RCMP;
        end
      end
      S_RCMP: begin
        if (st.out_free) begin
          cmd.push_entry = 1'b1;
          if (st.rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.walk_adv = 1'b1;
            state_nxt    = S_RRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/grouped_volume_sorted_start_lists_core.sv =====
// Top level of the grouped volume-sorted start/run list engine.
// Usage:
//  Input channel (in_valid/in_ready) takes one op item: clear, add running
//  entry, add starting entry, or read one group's list. Result channel
//  (out_valid/out_ready) returns one item per op, or one item per list entry
//  for a read; out_last marks the final item of each op.
//  The block works on one op at a time. Group search visits one table slot
//  per step (one group-table RAM read plus compare); a list walk visits one
//  entry per step (link/payload RAM read plus compare). A finished result
//  sits in an output register; the next op may be taken while it waits.
//  When the receiver stalls, a read pauses on its entry until the output
//  register frees up.
//  Reset clears the fill counts and control state; the table and pools
//  need no clearing pass, so the block is ready the cycle after reset.
module grouped_volume_sorted_start_lists_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_group_id,
  input  logic [15:0]        in_emitter_handle,
  input  logic [15:0]        in_volume,
  input  logic signed [15:0] in_pan_x,
  input  logic signed [15:0] in_pan_y,
  input  logic signed [15:0] in_pan_z,
  input  logic [13:0]        in_pitch_ratio,
  input  logic               in_list_select,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_emitter,
  output logic [15:0]        out_volume,
  output logic signed [15:0] out_pan_x,
  output logic signed [15:0] out_pan_y,
  output logic signed [15:0] out_pan_z,
  output logic [13:0]        out_pitch,
  output logic [6:0]         out_running_total,
  output logic               out_last
);

  gvssl_pkg::cmd_t  cmd;
  gvssl_pkg::stat_t st;

  gvssl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .st(st), .cmd(cmd)
  );

  gvssl_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_op(in_op), .in_group_id(in_group_id), .in_emitter_handle(in_emitter_handle),
    .in_volume(in_volume), .in_pan_x(in_pan_x), .in_pan_y(in_pan_y),
    .in_pan_z(in_pan_z), .in_pitch_ratio(in_pitch_ratio),
    .in_list_select(in_list_select),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_emitter(out_emitter), .out_volume(out_volume), .out_pan_x(out_pan_x),
    .out_pan_y(out_pan_y), .out_pan_z(out_pan_z), .out_pitch(out_pitch),
    .out_running_total(out_running_total), .out_last(out_last)
  );

endmodule

// ===== hdl/gvssl_checker.sv =====
// Port-level checks for the list engine, bound to the top level.
module gvssl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [15:0]        out_emitter,
  input logic [6:0]         out_running_total,
  input logic               out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_emitter) && $stable(out_last))
    else $error("stalled result changed");

  // One op at a time: no item taken right after another
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken twice in a row");

  // Only an ok result can be followed by more results of the same op
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gvssl_pkg::ST_OK |-> out_last)
    else $error("error result not final");

  // Unknown group reports no running count
  a_nf_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == gvssl_pkg::ST_NOT_FOUND |-> out_running_total == 7'd0)
    else $error("not found with count");

  // No result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind grouped_volume_sorted_start_lists_core gvssl_checker u_chk (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the grouped volume-sorted start/run list engine.
module testbench;

  // One result item of the block
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] emitter;
    logic [15:0] volume;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [13:0] pitch;
    logic [6:0]  total;
    logic        last;
  } list_res_t;

  // Predicts the engine's results and matches them against what arrives
  class list_scoreboard;
    logic [31:0]           keys[gvssl_pkg::GROUP_SLOTS];
    int                    shead[gvssl_pkg::GROUP_SLOTS];
    int                    rhead[gvssl_pkg::GROUP_SLOTS];
    int                    rtot[gvssl_pkg::GROUP_SLOTS];
    int                    slink[gvssl_pkg::POOL_ENTRIES];
    gvssl_pkg::start_pay_t spay[gvssl_pkg::POOL_ENTRIES];
    int                    rlink[gvssl_pkg::POOL_ENTRIES];
    gvssl_pkg::run_pay_t   rpay[gvssl_pkg::POOL_ENTRIES];
    int                    n_groups, n_start, n_run;
    list_res_t             pending[$];
    int                    mismatches;

    function int find_group(logic [31:0] key);
      for (int g = 0; g < n_groups; g++)
        if (keys[g] == key) return g;
      return -1;
    endfunction

    function logic [6:0] clamp(int t);
      return (t > 127) ? 7'd127 : 7'(t);
    endfunction

    function void push(logic [1:0] st, gvssl_pkg::start_pay_t p, int tot, logic lst);
      list_res_t r;
      r.status = st; r.emitter = p.emitter; r.volume = p.volume;
      r.px = p.px; r.py = p.py; r.pz = p.pz; r.pitch = p.pitch;
      r.total = clamp(tot); r.last = lst;
      pending.push_back(r);
    endfunction

    // Note an accepted input item and predict its results
    function void note_item(logic [1:0] op, logic [31:0] key, gvssl_pkg::start_pay_t p,
                            logic sel);
      gvssl_pkg::start_pay_t z;
      int g, prv, cur, n, cnt;
      z = '0;
      if (op == gvssl_pkg::OP_CLEAR) begin
        n_groups = 0; n_start = 0; n_run = 0;
        push(gvssl_pkg::ST_OK, z, 0, 1);
        return;
      end
      g = find_group(key);
      if (op == gvssl_pkg::OP_READ) begin
        if (g < 0) begin
          push(gvssl_pkg::ST_NOT_FOUND, z, 0, 1);
          return;
        end
        cnt = 0;
        cur = sel ? rhead[g] : shead[g];
        while (cur < gvssl_pkg::POOL_ENTRIES && cnt < gvssl_pkg::MAX_RESULTS) begin
          if (sel) begin
            z.emitter = rpay[cur].emitter; z.volume = rpay[cur].volume;
            cur = rlink[cur];
          end else begin
            z = spay[cur];
            cur = slink[cur];
          end
          cnt++;
          push(gvssl_pkg::ST_OK, z, rtot[g], 0);
          z = '0;
        end
        if (cnt == 0) push(gvssl_pkg::ST_OK, z, rtot[g], 1);
        else pending[pending.size()-1].last = 1;
        return;
      end
      if (g < 0) begin
        if (n_groups >= gvssl_pkg::GROUP_SLOTS) begin
          push(gvssl_pkg::ST_TABLE_FULL, z, 0, 1);
          return;
        end
        g = n_groups++;
        keys[g] = key; shead[g] = gvssl_pkg::POOL_ENTRIES;
        rhead[g] = gvssl_pkg::POOL_ENTRIES; rtot[g] = 0;
      end
      if (op == gvssl_pkg::OP_ADD_RUN) begin
        if (n_run >= gvssl_pkg::POOL_ENTRIES) begin
          push(gvssl_pkg::ST_POOL_FULL, z, rtot[g], 1);
          return;
        end
        // ascending: insert after all entries with volume <= new
        prv = gvssl_pkg::POOL_ENTRIES; cur = rhead[g];
        while (cur < gvssl_pkg::POOL_ENTRIES && rpay[cur].volume <= p.volume) begin
          prv = cur; cur = rlink[cur];
        end
        n = n_run++;
        rlink[n] = cur; rpay[n].emitter = p.emitter; rpay[n].volume = p.volume;
        if (prv == gvssl_pkg::POOL_ENTRIES) rhead[g] = n; else rlink[prv] = n;
        rtot[g]++;
      end else begin
        if (n_start >= gvssl_pkg::POOL_ENTRIES) begin
          push(gvssl_pkg::ST_POOL_FULL, z, rtot[g], 1);
          return;
        end
        // descending: insert before first entry with lower volume
        prv = gvssl_pkg::POOL_ENTRIES; cur = shead[g];
        while (cur < gvssl_pkg::POOL_ENTRIES && spay[cur].volume >= p.volume) begin
          prv = cur; cur = slink[cur];
        end
        n = n_start++;
        slink[n] = cur; spay[n] = p;
        if (prv == gvssl_pkg::POOL_ENTRIES) shead[g] = n; else slink[prv] = n;
      end
      push(gvssl_pkg::ST_OK, z, rtot[g], 1);
    endfunction

    // Check one accepted result against the oldest prediction
    function void check_result(list_res_t got);
      list_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h actual %h", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] in_op = '0;
  logic [31:0] in_group_id = '0;
  logic [15:0] in_emitter_handle = '0, in_volume = '0;
  logic signed [15:0] in_pan_x = '0, in_pan_y = '0, in_pan_z = '0;
  logic [13:0] in_pitch_ratio = '0;
  logic in_list_select = 0;
  logic [1:0] out_status;
  logic [15:0] out_emitter, out_volume;
  logic signed [15:0] out_pan_x, out_pan_y, out_pan_z;
  logic [13:0] out_pitch;
  logic [6:0] out_running_total;
  logic out_last;

  list_scoreboard board = new();
  bit quiet_tail = 0;
  int hold_off = 0;
  int idle_cycles = 0;
  logic [31:0] key_pool[8];

  grouped_volume_sorted_start_lists_core dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Note inputs and check results at each edge; count stalled cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_item(in_op, in_group_id,
          {in_emitter_handle, in_volume, in_pan_x, in_pan_y, in_pan_z, in_pitch_ratio},
          in_list_select);
      end
      if (out_valid && out_ready)
        board.check_result({out_status, out_emitter, out_volume, out_pan_x, out_pan_y,
                            out_pan_z, out_pitch, out_running_total, out_last});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      if (hold_off > 0) begin
        out_ready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until accepted, sometimes with a random gap before
  task automatic send_item(logic [1:0] op, logic [31:0] key, logic [15:0] em,
                           logic [15:0] vol, logic [15:0] px, logic [15:0] py,
                           logic [15:0] pz, logic [13:0] pit, logic sel);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1; in_op <= op; in_group_id <= key; in_emitter_handle <= em;
    in_volume <= vol; in_pan_x <= px; in_pan_y <= py; in_pan_z <= pz;
    in_pitch_ratio <= pit; in_list_select <= sel;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random(logic [1:0] op, logic [31:0] key, logic sel);
    logic [15:0] vol;
    case ($urandom_range(0, 5))
      0: vol = 16'd0;
      1: vol = 16'd32768;
      2: vol = 16'($urandom_range(0, 7) * 4096);
      default: vol = 16'($urandom_range(0, 32768));
    endcase
    send_item(op, key, 16'($urandom), vol, 16'($urandom_range(0, 65534) - 32767),
              16'($urandom_range(0, 65534) - 32767),
              16'($urandom_range(0, 65534) - 32767), 14'($urandom), sel);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_drained();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    logic [1:0] op;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, equal volumes, head insertion, unknown and empty reads
    send_item(gvssl_pkg::OP_READ, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_ADD_START, 32'hFFFF_FFFF, 16'hFFFF, 16'd32768, 16'sd32767,
              -16'sd32767, 16'sd32767, 14'h3FFF, 0);
    send_item(gvssl_pkg::OP_ADD_START, 32'hFFFF_FFFF, 16'h0001, 16'd100, -16'sd32767,
              16'sd32767, -16'sd32767, 14'h0, 0);
    send_item(gvssl_pkg::OP_ADD_START, 32'hFFFF_FFFF, 16'h0002, 16'd100, 16'sd1, 16'sd2,
              16'sd3, 14'd5, 0);
    send_item(gvssl_pkg::OP_ADD_START, 32'hFFFF_FFFF, 16'h0003, 16'd32768, 0, 0, 0,
              14'd1, 0);
    send_item(gvssl_pkg::OP_READ, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1);
    send_item(gvssl_pkg::OP_ADD_RUN, 32'h0, 16'h0000, 16'd0, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_ADD_RUN, 32'h0, 16'h0011, 16'd32768, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_ADD_RUN, 32'h0, 16'h0022, 16'd0, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_ADD_RUN, 32'h0, 16'h0033, 16'd500, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_READ, 32'h0, 0, 0, 0, 0, 0, 0, 1);
    send_item(gvssl_pkg::OP_READ, 32'h0, 0, 0, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_READ, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_READ, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 1);
    send_item(gvssl_pkg::OP_CLEAR, 32'hA5A5_A5A5, 16'hFFFF, 16'hFFFF, -16'sd1, -16'sd1,
              -16'sd1, 14'h3FFF, 1);
    send_item(gvssl_pkg::OP_READ, 32'h0, 0, 0, 0, 0, 0, 0, 1);

    // Fill the group table and the starting pool, one entry per group
    send_item(gvssl_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 64; i++)
      send_random(gvssl_pkg::OP_ADD_START, 32'hC0DE_0000 | 32'(i), 0);
    // Starting pool full, then group table full
    send_random(gvssl_pkg::OP_ADD_START, 32'hC0DE_0003, 0);
    send_random(gvssl_pkg::OP_ADD_RUN, 32'hDEAD_BEEF, 0);
    // Fill the running pool in one group, one more is refused
    for (int i = 0; i < 65; i++) send_random(gvssl_pkg::OP_ADD_RUN, 32'hC0DE_0000, 0);
    // Receiver holds off while reads pile up behind it
    hold_off = 400;
    send_item(gvssl_pkg::OP_READ, 32'hC0DE_0000, 0, 0, 0, 0, 0, 0, 1);
    send_item(gvssl_pkg::OP_READ, 32'hC0DE_0000, 0, 0, 0, 0, 0, 0, 0);
    send_item(gvssl_pkg::OP_READ, 32'hDEAD_BEEF, 0, 0, 0, 0, 0, 0, 1);
    wait_drained();

    // Random: mostly adds and reads on a few keys, occasional clears
    send_item(gvssl_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) key_pool[i] = (i == 0) ? 32'hFFFF_FFFF : 32'($urandom);
    for (int i = 0; i < 70; i++) begin
      if (i == 55) quiet_tail = 1;
      case ($urandom_range(0, 19))
        0: op = gvssl_pkg::OP_CLEAR;
        1, 2, 3, 4, 5, 6: op = gvssl_pkg::OP_ADD_RUN;
        7, 8, 9, 10, 11, 12: op = gvssl_pkg::OP_ADD_START;
        default: op = gvssl_pkg::OP_READ;
      endcase
      send_random(op, ($urandom_range(0, 9) == 0) ? 32'($urandom) :
                  key_pool[$urandom_range(0, 7)], 1'($urandom));
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
